// ===== rtl/core/spam_pkg.sv =====
// Shared widths, command codes and term types of the sparse polynomial merge.
`default_nettype none

package spam_pkg;

   localparam int unsigned MAX_TERMS_DEF = 32;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned COEF_W     = 16;
   localparam int unsigned POWER_W    = 16;
   localparam int unsigned SUM_W      = COEF_W + 1;
   localparam int unsigned REQ_DATA_W = COEF_W + POWER_W;
   localparam int unsigned RSP_FLD_W  = SUM_W + POWER_W;
   localparam int unsigned RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_START  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [COEF_W-1:0]  coef;
      logic [POWER_W-1:0] power;
   } term_type;

   typedef struct packed {
      logic take_a;
      logic take_b;
      logic empty;
   } pick_type;

endpackage

`default_nettype wire

// ===== rtl/core/spam_pick.sv =====
// Compare-and-add unit: picks the next merged term from the heads of both lists.
`default_nettype none

module spam_pick (
   input  spam_pkg::term_type                  a_term,
   input  spam_pkg::term_type                  b_term,
   input  logic                                a_has,
   input  logic                                b_has,
   output spam_pkg::pick_type                  pick,
   output logic signed [spam_pkg::SUM_W-1:0]   coef,
   output logic [spam_pkg::POWER_W-1:0]        power
);
   import spam_pkg::*;

   logic signed [SUM_W-1:0] a_ext;
   logic signed [SUM_W-1:0] b_ext;

   assign a_ext = {a_term.coef[COEF_W-1], a_term.coef};
   assign b_ext = {b_term.coef[COEF_W-1], b_term.coef};

   always_comb begin
      pick  = '0;
      coef  = '0;
      power = '0;
      if (a_has && b_has) begin
         if (a_term.power == b_term.power) begin
            pick.take_a = 1'b1;
            pick.take_b = 1'b1;
            coef        = a_ext + b_ext;
            power       = a_term.power;
         end else if (a_term.power > b_term.power) begin
            pick.take_b = 1'b1;
            coef        = b_ext;
            power       = b_term.power;
         end else begin
            pick.take_a = 1'b1;
            coef        = a_ext;
            power       = a_term.power;
         end
      end else if (a_has) begin
         pick.take_a = 1'b1;
         coef        = a_ext;
         power       = a_term.power;
      end else if (b_has) begin
         pick.take_b = 1'b1;
         coef        = b_ext;
         power       = b_term.power;
      end else begin
         // both lists empty: zero term, flagged
         pick.empty = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sparse_polynomial_add_merge.sv =====
// Top level of the sparse polynomial adder: term stores, merge sequencer, output register.
// Usage: load items (tuser = 0 for list A, 1 for list B) each store one term, up to MAX_TERMS
// per list; loads into a full list are dropped, and tuser = 3 is dropped too. A start item
// (tuser = 2) runs the merge: the block deasserts req_tready until the last result item has
// been loaded into the output register. Each result item passes through a fetch state that
// reads the head entries of both term memories (registered read), then an emit state in
// which the shared compare/add unit picks the next term and advances the list pointers; the
// emit state waits while the output register is full and not being taken. Equal exponents
// give one item with the 17-bit coefficient sum, kept even when it is zero. Two empty lists
// give a single item with zero fields, tlast and tuser set. Both term counts clear when the
// last item of a run is loaded. No clearing pass runs after reset: entries are only read
// below the fill count. Load items are accepted while a result item still waits to be taken.
`default_nettype none

module sparse_polynomial_add_merge #(
   parameter int unsigned MAX_TERMS = spam_pkg::MAX_TERMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [spam_pkg::REQ_DATA_W-1:0]     req_tdata,  // coef_in[15:0], power_in[31:16]
   input  logic [spam_pkg::CMD_W-1:0]          req_tuser,  // command[1:0]
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [spam_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // coef_out[16:0], power_out[32:17]
   output logic                                rsp_tlast,  // last_term
   output logic [0:0]                          rsp_tuser   // empty_result[0]
);
   import spam_pkg::*;

   localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);
   localparam int unsigned DEPTH = 1 << IDX_W;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_TERMS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        a_count_ff, a_count_in;
   logic [CNT_W-1:0]        b_count_ff, b_count_in;
   logic [CNT_W-1:0]        ia_ff, ia_in;
   logic [CNT_W-1:0]        ib_ff, ib_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [POWER_W-1:0]      rsp_power_ff, rsp_power_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   term_type                a_mem [DEPTH];
   term_type                b_mem [DEPTH];
   term_type                a_rd_ff;
   term_type                b_rd_ff;
   term_type                req_term;

   cmd_type                 cmd;
   logic                    req_accept;
   logic                    a_wr;
   logic                    b_wr;
   logic                    a_has;
   logic                    b_has;
   logic                    rsp_load;
   logic                    run_last;
   logic [CNT_W-1:0]        ia_next;
   logic [CNT_W-1:0]        ib_next;
   pick_type                pick;
   logic signed [SUM_W-1:0] pick_coef;
   logic [POWER_W-1:0]      pick_power;

   assign cmd            = cmd_type'(req_tuser);
   assign req_term.coef  = req_tdata[COEF_W-1:0];
   assign req_term.power = req_tdata[REQ_DATA_W-1:COEF_W];
   assign req_tready     = (state_ff == ST_IDLE);
   assign req_accept     = req_tvalid && req_tready;

   // store writes: append at the fill count, drop when full
   assign a_wr = req_accept && (cmd == CMD_LOAD_A) && (a_count_ff < FULL);
   assign b_wr = req_accept && (cmd == CMD_LOAD_B) && (b_count_ff < FULL);

   always_ff @(posedge clock) begin
      if (a_wr) begin
         a_mem[a_count_ff[IDX_W-1:0]] <= req_term;
      end
      if (b_wr) begin
         b_mem[b_count_ff[IDX_W-1:0]] <= req_term;
      end
   end

   // registered read at the list heads; pointers only advance in the emit state (a start item resets them)
   always_ff @(posedge clock) begin
      a_rd_ff <= a_mem[ia_ff[IDX_W-1:0]];
      b_rd_ff <= b_mem[ib_ff[IDX_W-1:0]];
   end

   assign a_has = (ia_ff < a_count_ff);
   assign b_has = (ib_ff < b_count_ff);

   spam_pick u_pick (
      .a_term (a_rd_ff),
      .b_term (b_rd_ff),
      .a_has  (a_has),
      .b_has  (b_has),
      .pick   (pick),
      .coef   (pick_coef),
      .power  (pick_power)
   );

   assign ia_next  = ia_ff + CNT_W'(pick.take_a);
   assign ib_next  = ib_ff + CNT_W'(pick.take_b);
   assign run_last = (ia_next >= a_count_ff) && (ib_next >= b_count_ff);
   // load the output register when it is free or being emptied this cycle
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      a_count_in   = a_count_ff;
      b_count_in   = b_count_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_coef_in  = rsp_coef_ff;
      rsp_power_in = rsp_power_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (cmd)
                  CMD_LOAD_A: begin
                     if (a_wr) begin
                        a_count_in = a_count_ff + CNT_W'(1);
                     end
                  end
                  CMD_LOAD_B: begin
                     if (b_wr) begin
                        b_count_in = b_count_ff + CNT_W'(1);
                     end
                  end
                  CMD_START: begin
                     ia_in    = '0;
                     ib_in    = '0;
                     state_in = ST_FETCH;
                  end
                  default: begin
                     // unused command: drop the item
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = pick_coef;
               rsp_power_in = pick_power;
               rsp_last_in  = run_last;
               rsp_empty_in = pick.empty;
               ia_in        = ia_next;
               ib_in        = ib_next;
               if (run_last) begin
                  a_count_in = '0;
                  b_count_in = '0;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_count_ff   <= '0;
         b_count_ff   <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_count_ff   <= a_count_in;
         b_count_ff   <= b_count_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_coef_ff  <= rsp_coef_in;
      rsp_power_ff <= rsp_power_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{(RSP_DATA_W - RSP_FLD_W){1'b0}}, rsp_power_ff, rsp_coef_ff};
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_empty_ff;

   // fill counts never pass the capacity
   assert property (@(posedge clock) disable iff (reset)
      (a_count_ff <= FULL) && (b_count_ff <= FULL))
      else $error("term count beyond capacity");

   // merge pointers never run past the stored terms
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (ia_ff <= a_count_ff) && (ib_ff <= b_count_ff))
      else $error("merge pointer beyond fill count");

   // loading the final item of a run ends the run with both lists cleared
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && run_last) |=> (state_ff == ST_IDLE) && (a_count_ff == '0)
                                 && (b_count_ff == '0) && rsp_valid_ff && rsp_last_ff)
      else $error("run did not close after its last item");

   // an empty-run item is the only item of its run and carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> rsp_last_ff && (rsp_coef_ff == '0)
                                         && (rsp_power_ff == '0))
      else $error("empty-run item malformed");

endmodule

`default_nettype wire
